>>> sv/deq_pkg.sv
package deq_pkg;

  // Ring geometry
  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Fixed field widths of the channels
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int OCC_W   = 5;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_POP_BACK   = 3'd1,
    REQ_PUSH_FRONT = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ_INDEX = 3'd4,
    REQ_SEARCH     = 3'd5
  } req_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_PUSH,
    KIND_POP,
    KIND_READ,
    KIND_SEARCH
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic                   at_front;
    logic [WORD_BITS-1:0]   word;
    logic [POS_W-1:0]       pos;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_word;
    logic               found;
    logic [OCC_W-1:0]   occupancy;
    status_t            status;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH
  } back_state_t;

  // Sign-extend the 32-bit field value, keep WORD_BITS of it
  function automatic logic [WORD_BITS-1:0] to_word(input logic [VALUE_W-1:0] v);
    logic [63:0] ext;
    ext = {{(64 - VALUE_W){v[VALUE_W-1]}}, v};
    return ext[WORD_BITS-1:0];
  endfunction

  // Zero-extend or truncate a stored word onto the 32-bit field
  function automatic logic [VALUE_W-1:0] from_word(input logic [WORD_BITS-1:0] w);
    logic [63:0] ext;
    ext = {{(64 - WORD_BITS){1'b0}}, w};
    return ext[VALUE_W-1:0];
  endfunction

  // Ring slot at an offset from base; offset never exceeds DEPTH
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> sv/deq_if.sv
interface deq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] value;
  logic [3:0]         position;

  modport source (output valid, req_type, value, position, input ready);
  modport sink   (input valid, req_type, value, position, output ready);
endinterface

interface deq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_word;
  logic               found;
  logic [4:0]         occupancy;
  logic [1:0]         status;

  modport source (output valid, read_word, found, occupancy, status, input ready);
  modport sink   (input valid, read_word, found, occupancy, status, output ready);
endinterface

>>> sv/deq_front.sv
module deq_front (
  input  logic          clk,
  input  logic          rst_n,
  deq_in_if.sink        in_if,
  output logic          cmd_valid,
  output deq_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import deq_pkg::*;

  cmd_t       fifo_r [FIFO_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  logic       pop;
  cmd_t       new_cmd;

  // Classify the incoming transaction
  always_comb begin
    new_cmd.word     = to_word(in_if.value);
    new_cmd.pos      = in_if.position;
    new_cmd.at_front = 1'b0;
    case (in_if.req_type)
      REQ_PUSH_BACK:  new_cmd.kind = KIND_PUSH;
      REQ_POP_BACK:   new_cmd.kind = KIND_POP;
      REQ_PUSH_FRONT: begin
        new_cmd.kind     = KIND_PUSH;
        new_cmd.at_front = 1'b1;
      end
      REQ_POP_FRONT:  begin
        new_cmd.kind     = KIND_POP;
        new_cmd.at_front = 1'b1;
      end
      REQ_READ_INDEX: new_cmd.kind = KIND_READ;
      REQ_SEARCH:     new_cmd.kind = KIND_SEARCH;
      default:        new_cmd.kind = KIND_NOP;
    endcase
  end

  // Two-entry command queue
  assign in_if.ready = (fill_r != 2'(FIFO_DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign pop         = cmd_pop && cmd_valid;
  assign cmd_valid   = (fill_r != 2'd0);
  assign cmd         = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_cmd;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 2'(FIFO_DEPTH))
    else $error("command queue overfilled");
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'(FIFO_DEPTH)) && !pop |=> (fill_r == 2'(FIFO_DEPTH)))
    else $error("command queue lost an entry while full");
  a_full_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'(FIFO_DEPTH)) |-> !in_if.ready)
    else $error("input ready while the command queue is full");
`endif

endmodule

>>> sv/deq_back.sv
module deq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  deq_pkg::cmd_t cmd,
  output logic          cmd_pop,
  deq_out_if.source     out_if
);
  import deq_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  back_state_t          state_r, state_nxt;
  logic [PTR_W-1:0]     front_r, front_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [WORD_BITS-1:0] word_r;
  logic                 out_valid_r;
  res_t                 res_r, res_nxt;
  logic                 out_load;

  logic [PTR_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [PTR_W-1:0]     wr_addr;
  logic                 start;

  assign start = (state_r == S_IDLE) && cmd_valid && !out_valid_r;

  // Execute one command; reads and searches go through the registered memory port, a search walking the ring
  always_comb begin
    state_nxt         = state_r;
    front_nxt         = front_r;
    count_nxt         = count_r;
    idx_nxt           = idx_r;
    cmd_pop           = 1'b0;
    out_load          = 1'b0;
    rd_addr           = front_r;
    wr_en             = 1'b0;
    wr_addr           = ring_add(front_r, count_r);
    res_nxt.read_word = '0;
    res_nxt.found     = 1'b0;
    res_nxt.status    = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            KIND_PUSH: begin
              out_load = 1'b1;
              if (count_r == CNT_W'(DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (cmd.at_front) begin
                  front_nxt = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - PTR_W'(1);
                  wr_addr   = front_nxt;
                end
              end
            end
            KIND_POP: begin
              out_load = 1'b1;
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                if (cmd.at_front) begin
                  front_nxt = (front_r == PTR_W'(DEPTH - 1)) ? '0 : front_r + PTR_W'(1);
                end
              end
            end
            KIND_READ: begin
              if (16'(cmd.pos) >= 16'(count_r)) begin
                out_load       = 1'b1;
                res_nxt.status = ST_RANGE;
              end else begin
                rd_addr   = ring_add(front_r, CNT_W'(cmd.pos));
                state_nxt = S_READ;
              end
            end
            KIND_SEARCH: begin
              if (count_r == '0) begin
                out_load = 1'b1;
              end else begin
                idx_nxt   = '0;
                rd_addr   = front_r;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_load          = 1'b1;
        res_nxt.read_word = from_word(rd_data_r);
        state_nxt         = S_IDLE;
      end
      S_SEARCH: begin
        if (rd_data_r == word_r) begin
          out_load      = 1'b1;
          res_nxt.found = 1'b1;
          state_nxt     = S_IDLE;
        end else if (idx_r == count_r - CNT_W'(1)) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
          rd_addr = ring_add(front_r, idx_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res_nxt.occupancy = OCC_W'(count_nxt);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      word_r <= cmd.word;
    end
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  // Ring storage, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.word;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.read_word = $signed(res_r.read_word);
  assign out_if.found     = res_r.found;
  assign out_if.occupancy = res_r.occupancy;
  assign out_if.status    = res_r.status;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending while a command is in flight");
  a_search_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (idx_r < count_r))
    else $error("search index outside the held entries");
  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(count_r) && $stable(front_r))
    else $error("queue state changed during a read or search");
`endif

endmodule

>>> sv/double_ended_queue_with_search.sv
// Bounded double-ended queue of signed words in a ring, with indexed read and search.
// in_if  : request transactions (req_type, value, position), valid/ready handshake.
//          Codes: push back, pop back, push front, pop front, read index, search.
// out_if : one result transaction per request (read_word, found, occupancy, status),
//          delivered in request order.
// A two-entry command queue sits in front of the execution unit, so requests are
// taken while a result waits at the output.
// With the execution unit idle, push, pop and requests that fail or do nothing
// load the result register directly; an indexed read first passes through one
// registered memory read, and a search reads the ring entry by entry until a match
// or the last held entry (up to the occupancy, at most DEPTH entries). The next
// request starts only after the output register is taken; the single ring read
// port, walked one entry per cycle, sets the search time.
// Reset (synchronous, rst_n low) empties the queue and drops queued requests and
// any pending result. When out_if.ready is low the result holds, execution stops,
// and in_if.ready drops once the command queue is full.
module double_ended_queue_with_search (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_if,
  deq_out_if.source out_if
);
  import deq_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  deq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_if    (out_if)
  );

endmodule

>>> verif/double_ended_queue_with_search_tb.sv
`timescale 1ns / 100ps

module double_ended_queue_with_search_tb;
  import deq_pkg::*;

  localparam int          CLK_PERIOD    = 8;
  localparam int          RESET_CYCLES  = 5;
  localparam int          RANDOM_ITEMS  = 1200;
  localparam int          PHASE_ITEMS   = 150;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          IDLE_PCT      = 13;
  localparam logic [2:0]  REQ_SPARE_A   = 3'd6;
  localparam logic [2:0]  REQ_SPARE_B   = 3'd7;

  // Traffic mix of the random part
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_t;

  // Deque shadow: predicts one result per request and checks results in order
  class deque_tracker;
    logic [WORD_BITS-1:0] ring_words [DEPTH];
    int unsigned          head_slot      = 0;
    int unsigned          held_count     = 0;
    int unsigned          mismatch_count = 0;
    res_t                 expected_results [$];

    function logic [WORD_BITS-1:0] held_word(int unsigned idx);
      return ring_words[(head_slot + idx) % DEPTH];
    endfunction

    // Update the shadow for an accepted request and queue its result
    function void note_request(logic [2:0] req, logic [31:0] value, logic [3:0] pos);
      res_t                 res;
      logic signed [63:0]   wide;
      logic [63:0]          rd_wide;
      logic [WORD_BITS-1:0] word;
      int unsigned          i;
      res = '0;
      res.status = ST_OK;
      wide = $signed(value);
      word = wide[WORD_BITS-1:0];
      case (req)
        REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
          if (held_count >= DEPTH) begin
            res.status = ST_FULL;
          end else if (req == REQ_PUSH_BACK) begin
            ring_words[(head_slot + held_count) % DEPTH] = word;
            held_count++;
          end else begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            ring_words[head_slot] = word;
            held_count++;
          end
        end
        REQ_POP_BACK, REQ_POP_FRONT: begin
          if (held_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            if (req == REQ_POP_FRONT) head_slot = (head_slot + 1) % DEPTH;
            held_count--;
          end
        end
        REQ_READ_INDEX: begin
          if (pos >= held_count) begin
            res.status = ST_RANGE;
          end else begin
            rd_wide = 64'(held_word(pos));
            res.read_word = rd_wide[31:0];
          end
        end
        REQ_SEARCH: begin
          for (i = 0; i < held_count; i++) begin
            if (held_word(i) == word) res.found = 1'b1;
          end
        end
        default: ;
      endcase
      res.occupancy = held_count[OCC_W-1:0];
      expected_results.push_back(res);
    endfunction

    function void report(string field, longint exp_v, longint act_v);
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
      mismatch_count++;
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(res_t actual);
      res_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d occupancy %0d",
                 $time, actual.status, actual.occupancy);
        mismatch_count++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (actual.read_word !== exp_r.read_word)
        report("read_word", $signed(exp_r.read_word), $signed(actual.read_word));
      if (actual.found !== exp_r.found)
        report("found", exp_r.found, actual.found);
      if (actual.occupancy !== exp_r.occupancy)
        report("occupancy", exp_r.occupancy, actual.occupancy);
      if (actual.status !== exp_r.status)
        report("status", exp_r.status, actual.status);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  req_if ();
  deq_out_if res_if ();

  deque_tracker tracker;
  bit           no_idle     = 1'b0;
  bit           hold_output = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  double_ended_queue_with_search i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_if),
    .out_if (res_if)
  );

  // Offer one request, with random idle cycles ahead of it
  task automatic send_request(logic [2:0] req, logic [31:0] value, logic [3:0] pos);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= req;
    req_if.value    <= value;
    req_if.position <= pos;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    tracker.note_request(req, value, pos);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // Search for a held word half the time, so hits are common
  function automatic logic [31:0] search_word();
    logic [63:0] w;
    if (tracker.held_count > 0 && $urandom_range(0, 1) == 1) begin
      w = 64'(tracker.held_word($urandom_range(0, tracker.held_count - 1)));
      return w[31:0];
    end
    return random_word();
  endfunction

  function automatic logic [3:0] read_pos();
    if (tracker.held_count > 0 && $urandom_range(0, 9) < 7)
      return 4'($urandom_range(0, tracker.held_count - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  // Result side: random backpressure, long hold-off on request
  initial begin
    int   hold_left;
    res_t actual;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        actual.read_word = res_if.read_word;
        actual.found     = res_if.found;
        actual.occupancy = res_if.occupancy;
        actual.status    = status_t'(res_if.status);
        tracker.check_result(actual);
      end
      if (hold_output) begin
        hold_left   = HOLD_CYCLES;
        hold_output = 1'b0;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: cycles without any transaction on either channel
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    wait (rst_n === 1'b1);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    int          n;
    int unsigned r;
    int unsigned push_pct;
    int unsigned pop_pct;
    mix_t        mix;
    logic [2:0]  req;
    tracker = new;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_PUSH_BACK;
    req_if.value    <= '0;
    req_if.position <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue: failed pops, read out of range, search, unused codes
    send_request(REQ_POP_BACK, 32'd0, 4'd0);
    send_request(REQ_POP_FRONT, 32'd0, 4'd0);
    send_request(REQ_READ_INDEX, 32'd0, 4'd0);
    send_request(REQ_SEARCH, 32'd0, 4'd0);
    send_request(REQ_SPARE_A, 32'hFFFF_FFFF, 4'hF);
    send_request(REQ_SPARE_B, 32'h1234_5678, 4'h5);

    // Extremes at both ends, reads and searches
    send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF, 4'd0);
    send_request(REQ_PUSH_FRONT, 32'h8000_0000, 4'd0);
    send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
    send_request(REQ_READ_INDEX, 32'd0, 4'd0);
    send_request(REQ_READ_INDEX, 32'd0, 4'd1);
    send_request(REQ_READ_INDEX, 32'd0, 4'd2);
    send_request(REQ_READ_INDEX, 32'd0, 4'd3);
    send_request(REQ_READ_INDEX, 32'd0, 4'hF);
    send_request(REQ_SEARCH, 32'h8000_0000, 4'd0);
    send_request(REQ_SEARCH, 32'd5, 4'd0);
    send_request(REQ_POP_BACK, 32'd0, 4'd0);
    send_request(REQ_POP_FRONT, 32'd0, 4'd0);

    // Last entry out: queue empties, then front push into empty queue
    send_request(REQ_POP_BACK, 32'd0, 4'd0);
    send_request(REQ_PUSH_FRONT, 32'h0000_0000, 4'd0);
    send_request(REQ_READ_INDEX, 32'd0, 4'd0);
    send_request(REQ_POP_FRONT, 32'd0, 4'd0);

    // Random traffic in phases that fill, drain or mix
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      mix = mix_t'((n / PHASE_ITEMS) % 3);
      no_idle = (n >= 400 && n < 550);
      if (n == 100 || n == 1000) hold_output = 1'b1;
      if (n == 600) wait_drained();
      case (mix)
        MIX_FILL:  begin push_pct = 65; pop_pct = 10; end
        MIX_DRAIN: begin push_pct = 15; pop_pct = 60; end
        default:   begin push_pct = 35; pop_pct = 30; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 2) begin
        req = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
        send_request(req, random_word(), 4'($urandom_range(0, 15)));
      end else if (r < 2 + push_pct) begin
        req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        send_request(req, random_word(), 4'($urandom_range(0, 15)));
      end else if (r < 2 + push_pct + pop_pct) begin
        req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
        send_request(req, random_word(), 4'($urandom_range(0, 15)));
      end else if (r % 2 == 0) begin
        send_request(REQ_READ_INDEX, random_word(), read_pos());
      end else begin
        send_request(REQ_SEARCH, search_word(), 4'($urandom_range(0, 15)));
      end
    end
    no_idle = 1'b0;

    // Drain, then idle for DRAIN_CYCLES before the final check
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_front.sv
sv/deq_back.sv
sv/double_ended_queue_with_search.sv
verif/double_ended_queue_with_search_tb.sv
